[sv/wse_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes, types and the opcode decoder for the i32 stack executor.
package wse_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Datapath and field widths
  localparam int DATA_W      = 32;
  localparam int OPC_W       = 8;
  localparam int DEPTH_OUT_W = 7;
  localparam int DIV_STEP_W  = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] SIGNED_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] MINUS_ONE  = {DATA_W{1'b1}};

  // Opcode bytes
  localparam logic [OPC_W-1:0] OPC_END   = 8'h0B;
  localparam logic [OPC_W-1:0] OPC_DROP  = 8'h1A;
  localparam logic [OPC_W-1:0] OPC_CONST = 8'h41;
  localparam logic [OPC_W-1:0] OPC_ADD   = 8'h6A;
  localparam logic [OPC_W-1:0] OPC_SUB   = 8'h6B;
  localparam logic [OPC_W-1:0] OPC_MUL   = 8'h6C;
  localparam logic [OPC_W-1:0] OPC_DIVS  = 8'h6D;
  localparam logic [OPC_W-1:0] OPC_DIVU  = 8'h6E;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_END   = 3'd1,
    ST_FULL  = 3'd2,
    ST_FEW   = 3'd3,
    ST_DIV0  = 3'd4,
    ST_OVF   = 3'd5,
    ST_UNSUP = 3'd6
  } status_e;

  // Decoded instruction class
  typedef enum logic [3:0] {
    OP_CONST,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIVS,
    OP_DIVU,
    OP_DROP,
    OP_END,
    OP_UNSUP
  } op_class_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic    accept;       // latch the request payload
    logic    rd_second;    // read address: 1 = count-2, 0 = count-1
    logic    push_imm;     // push the immediate
    logic    load_a;       // capture second-from-top operand
    logic    pop1;         // count -= 1
    logic    pop2;         // count -= 2, nothing pushed
    logic    alu_push;     // replace two operands by the ALU result
    logic    div_start;    // launch the divider
    logic    div_push;     // replace two operands by the quotient
    logic    top_from_rd;  // refresh cached top from the read port
    logic    load_out;     // load the output register
    status_e out_status;
  } ctrl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    op_class_e op;
    logic      cnt_zero;
    logic      cnt_full;
    logic      cnt_lt2;
    logic      b_zero;
    logic      divs_ovf;
    logic      div_done;
  } dp_status_t;

  function automatic op_class_e decode_op(input logic [OPC_W-1:0] opc);
    op_class_e cls;
    unique case (opc)
      OPC_CONST: cls = OP_CONST;
      OPC_ADD:   cls = OP_ADD;
      OPC_SUB:   cls = OP_SUB;
      OPC_MUL:   cls = OP_MUL;
      OPC_DIVS:  cls = OP_DIVS;
      OPC_DIVU:  cls = OP_DIVU;
      OPC_DROP:  cls = OP_DROP;
      OPC_END:   cls = OP_END;
      default:   cls = OP_UNSUP;
    endcase
    return cls;
  endfunction

endpackage

[sv/wse_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for instruction requests and results.
interface wse_req_if;
  import wse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OPC_W-1:0]         req_type;
  logic signed [DATA_W-1:0] immediate;

  modport source (output valid, output req_type, output immediate, input ready);
  modport sink   (input valid, input req_type, input immediate, output ready);
endinterface

interface wse_rsp_if;
  import wse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic signed [DATA_W-1:0] top_value;
  logic [DEPTH_OUT_W-1:0]   stack_depth;

  modport source (output valid, output status, output top_value, output stack_depth,
                  input ready);
  modport sink   (input valid, input status, input top_value, input stack_depth,
                  output ready);
endinterface

[sv/wse_div.sv]
`timescale 1ns / 1ps
// Radix-2 restoring divider, signed or unsigned, one quotient bit per cycle.
module wse_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        signed_i,
  input  logic [wse_pkg::DATA_W-1:0]  dividend_i,
  input  logic [wse_pkg::DATA_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [wse_pkg::DATA_W-1:0]  quotient_o
);
  import wse_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_STEP_W-1:0] step_q, step_d;
  logic [DATA_W-1:0]     rem_q, rem_d;
  logic [DATA_W-1:0]     quo_q, quo_d;
  logic [DATA_W-1:0]     den_q, den_d;
  logic                  neg_q, neg_d;

  logic                  neg_a, neg_b;
  logic [DATA_W:0]       shifted;
  logic [DATA_W:0]       diff;
  logic                  fits;

  // Operand magnitudes and one restoring step
  assign neg_a   = signed_i & dividend_i[DATA_W-1];
  assign neg_b   = signed_i & divisor_i[DATA_W-1];
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = (shifted >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = neg_a ? (DATA_W'(0) - dividend_i) : dividend_i;
      den_d  = neg_b ? (DATA_W'(0) - divisor_i) : divisor_i;
      neg_d  = neg_a ^ neg_b;
    end else if (busy_q) begin
      rem_d  = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_d  = {quo_q[DATA_W-2:0], fits};
      step_d = step_q + DIV_STEP_W'(1);
      if (step_q == DIV_STEP_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

  // A started division is busy in the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider not busy after start");

  // Done and busy never overlap
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");

endmodule

[sv/wse_dp.sv]
`timescale 1ns / 1ps
// Datapath: operand stack memory, cached top, ALU, divider and result register.
module wse_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wse_pkg::ctrl_cmd_t             cmd_i,
  output wse_pkg::dp_status_t            stat_o,
  input  logic [wse_pkg::OPC_W-1:0]      req_type_i,
  input  logic [wse_pkg::DATA_W-1:0]     immediate_i,
  output logic [2:0]                     status_o,
  output logic [wse_pkg::DATA_W-1:0]     top_value_o,
  output logic [wse_pkg::DEPTH_OUT_W-1:0] stack_depth_o
);
  import wse_pkg::*;

  // Operand stack, contents undefined until pushed
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] top_q, top_d;
  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] imm_q;
  op_class_e         op_q;

  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [DATA_W-1:0] wdata, alu_res, div_q;
  logic              we;
  logic              div_busy, div_done;

  logic [2:0]             out_status_q;
  logic [DATA_W-1:0]      out_top_q;
  logic [DEPTH_OUT_W-1:0] out_depth_q;

  assign cnt_m1 = cnt_q - CNT_W'(1);
  assign cnt_m2 = cnt_q - CNT_W'(2);

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= decode_op(req_type_i);
      imm_q <= immediate_i;
    end
    if (cmd_i.load_a) begin
      a_q <= rdata_q;
    end
  end

  // ALU for the binary ops add, sub and mul
  always_comb begin
    unique case (op_q)
      OP_ADD:  alu_res = a_q + top_q;
      OP_SUB:  alu_res = a_q - top_q;
      OP_MUL:  alu_res = a_q * top_q;
      default: alu_res = '0;
    endcase
  end

  wse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .signed_i   (op_q == OP_DIVS),
    .dividend_i (rdata_q),
    .divisor_i  (top_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Memory port selection
  assign raddr = cmd_i.rd_second ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
  assign we    = cmd_i.push_imm | cmd_i.alu_push | cmd_i.div_push;
  assign waddr = cmd_i.push_imm ? cnt_q[ADDR_W-1:0] : cnt_m2[ADDR_W-1:0];
  assign wdata = cmd_i.push_imm ? imm_q : (cmd_i.div_push ? div_q : alu_res);

  always_ff @(posedge clk_i) begin
    if (we) begin
      stack_mem[waddr] <= wdata;
    end
    rdata_q <= stack_mem[raddr];
  end

  // Count and cached top
  always_comb begin
    cnt_d = cnt_q;
    top_d = top_q;
    priority if (cmd_i.push_imm) begin
      cnt_d = cnt_q + CNT_W'(1);
      top_d = imm_q;
    end else if (cmd_i.alu_push || cmd_i.div_push) begin
      cnt_d = cnt_m1;
      top_d = wdata;
    end else if (cmd_i.pop1) begin
      cnt_d = cnt_m1;
    end else if (cmd_i.pop2) begin
      cnt_d = cnt_m2;
    end else if (cmd_i.top_from_rd) begin
      top_d = rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.out_status;
      out_top_q    <= (cnt_q == '0) ? '0 : top_q;
      out_depth_q  <= DEPTH_OUT_W'(cnt_q);
    end
  end

  assign status_o      = out_status_q;
  assign top_value_o   = out_top_q;
  assign stack_depth_o = out_depth_q;

  // Status toward the controller
  always_comb begin
    stat_o.op       = op_q;
    stat_o.cnt_zero = (cnt_q == '0);
    stat_o.cnt_full = (cnt_q == CNT_W'(STACK_DEPTH));
    stat_o.cnt_lt2  = (cnt_q < CNT_W'(2));
    stat_o.b_zero   = (top_q == '0);
    stat_o.divs_ovf = (rdata_q == SIGNED_MIN) && (top_q == MINUS_ONE);
    stat_o.div_done = div_done;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_imm |-> (cnt_q != CNT_W'(STACK_DEPTH)))
    else $error("push on full stack");

  a_binop_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.alu_push || cmd_i.div_push || cmd_i.pop2) |-> (cnt_q >= CNT_W'(2)))
    else $error("binary result without two operands");

  a_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

[sv/wse_ctrl.sv]
`timescale 1ns / 1ps
// Controller: instruction sequencing state machine and channel handshakes.
module wse_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  input  wse_pkg::dp_status_t  stat_i,
  output wse_pkg::ctrl_cmd_t   cmd_o
);
  import wse_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_READ    = 3'd2;
  localparam logic [2:0] S_ALU     = 3'd3;
  localparam logic [2:0] S_DIV     = 3'd4;
  localparam logic [2:0] S_REFRESH = 3'd5;
  localparam logic [2:0] S_REFWAIT = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state_q, state_d;
  status_e    st_q, st_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       out_free;

  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    st_d             = st_q;
    cmd_o            = '0;
    cmd_o.out_status = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        st_d    = ST_OK;
        state_d = S_DONE;
        unique case (stat_i.op)
          OP_CONST: begin
            if (stat_i.cnt_full) begin
              st_d = ST_FULL;
            end else begin
              cmd_o.push_imm = 1'b1;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIVS, OP_DIVU: begin
            if (stat_i.cnt_lt2) begin
              st_d = ST_FEW;
            end else begin
              cmd_o.rd_second = 1'b1;
              state_d         = S_READ;
            end
          end
          OP_DROP: begin
            if (stat_i.cnt_zero) begin
              st_d = ST_FEW;
            end else begin
              cmd_o.pop1 = 1'b1;
              state_d    = S_REFRESH;
            end
          end
          OP_END:  st_d = ST_END;
          default: st_d = ST_UNSUP;
        endcase
      end
      S_READ: begin
        cmd_o.load_a = 1'b1;
        priority if (stat_i.op == OP_ADD || stat_i.op == OP_SUB ||
                     stat_i.op == OP_MUL) begin
          state_d = S_ALU;
        end else if (stat_i.b_zero) begin
          st_d       = ST_DIV0;
          cmd_o.pop2 = 1'b1;
          state_d    = S_REFRESH;
        end else if (stat_i.op == OP_DIVS && stat_i.divs_ovf) begin
          st_d       = ST_OVF;
          cmd_o.pop2 = 1'b1;
          state_d    = S_REFRESH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_ALU: begin
        cmd_o.alu_push = 1'b1;
        state_d        = S_DONE;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.div_push = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_REFRESH: begin
        // new top lives one below the count; empty stack reports zero
        if (stat_i.cnt_zero) begin
          state_d = S_DONE;
        end else begin
          state_d = S_REFWAIT;
        end
      end
      S_REFWAIT: begin
        cmd_o.top_from_rd = 1'b1;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output transaction valid
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= ST_OK;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // The result register is never overwritten while still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!rsp_valid_q || rsp_ready_i))
    else $error("result overwritten before taken");

  // One instruction in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> !req_ready_o)
    else $error("second request accepted while busy");

  // A loaded result is offered in the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> rsp_valid_q)
    else $error("loaded result not offered");

endmodule

[sv/wasm_i32_stack_executor.sv]
`timescale 1ns / 1ps
// Top level of the WebAssembly i32 operand stack executor.
//
// Usage: each request transaction on req_i carries one opcode byte (req_type)
// and a decoded signed immediate used only by i32.const. For each request one
// response transaction on rsp_o reports status, the top of stack (zero when
// empty) and the stack depth after the instruction.
// One instruction is in flight at a time, and the 32-step radix-2 divider makes
// division the slowest instruction. Drop and the divide-by-zero and overflow
// cases skip the top refresh read when the stack ends up empty.
// The response sits in an output register, so a new request is taken while
// an earlier response waits; if the receiver stalls, the next instruction
// completes and then holds until the register frees.
// Reset empties the stack and clears both channels; stack contents are not
// cleared, as every readable entry is written by a push first.
module wasm_i32_stack_executor (
  input  logic      clk_i,
  input  logic      rst_ni,
  wse_req_if.sink   req_i,
  wse_rsp_if.source rsp_o
);
  import wse_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  wse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  wse_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_type_i    (req_i.req_type),
    .immediate_i   (req_i.immediate),
    .status_o      (rsp_o.status),
    .top_value_o   (rsp_o.top_value),
    .stack_depth_o (rsp_o.stack_depth)
  );

endmodule
